>>> rtl/core/flash_led_sequence_controller_core_assert.svh
// Assertion macros shared by the checker of the flash LED sequence controller.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef FLASH_LED_SEQUENCE_CONTROLLER_CORE_ASSERT_SVH
`define FLASH_LED_SEQUENCE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flsc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FLSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flsc assertion failed");

`endif

>>> rtl/core/flsc_pkg.sv
// Shared types, codes and the LED table of the flash LED sequence controller.
// Used by every module of the block; depends on nothing else.
package flsc_pkg;

    localparam int PATTERN_BITS = 16;
    localparam int LED_TOTAL_DEF = 60;
    localparam int TABLE_DEPTH = 64;
    localparam int INDEX_BITS = 7;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    typedef logic [PATTERN_BITS-1:0] t_pattern;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_FLASH  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PHASE_RELEASED = 2'd0,
        PHASE_PRESSED  = 2'd1,
        PHASE_LONG     = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        REG_BUTTON_DEBOUNCE = 3'd0,
        REG_FLASH_DEBOUNCE  = 3'd1,
        REG_LONG_PRESS      = 3'd2,
        REG_EXPOSURE_LIMIT  = 3'd3,
        REG_PILOT_PATTERN   = 3'd4
    } t_reg;

    localparam logic [7:0]  BUTTON_DEBOUNCE_RST = 8'd20;
    localparam logic [7:0]  FLASH_DEBOUNCE_RST  = 8'd2;
    localparam logic [15:0] LONG_PRESS_RST      = 16'd1000;
    localparam logic [15:0] EXPOSURE_LIMIT_RST  = 16'd3906;
    localparam t_pattern    PILOT_PATTERN_RST   = t_pattern'(16'hFFFF);
    localparam logic [15:0] WATCHDOG_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  button_debounce;
        logic [7:0]  flash_debounce;
        logic [15:0] long_press;
        logic [15:0] exposure_limit;
        t_pattern    pilot_pattern;
    } t_cfg;

    typedef struct packed {
        t_pattern              led_drive;
        logic                  led_enable;
        logic                  camera_wake;
        logic                  camera_trigger;
        logic                  ready_light;
        logic [INDEX_BITS-1:0] shot_index;
        t_phase                phase;
    } t_view;

    localparam t_pattern LED_TABLE [TABLE_DEPTH] = '{
        16'h0101, 16'h0401, 16'h1001, 16'h4001,
        16'h0102, 16'h0202, 16'h0402, 16'h0802, 16'h1002, 16'h2002, 16'h4002, 16'h8002,
        16'h0108, 16'h1008, 16'h0208, 16'h2008, 16'h0408, 16'h4008, 16'h0808, 16'h8008,
        16'h1004, 16'h0104, 16'h2004, 16'h0204, 16'h4004, 16'h0404, 16'h8004, 16'h0804,
        16'h0120, 16'h1020, 16'h0220, 16'h2020, 16'h0420, 16'h4020, 16'h0820, 16'h8020,
        16'h1010, 16'h0110, 16'h2010, 16'h0210, 16'h4010, 16'h0410, 16'h8010, 16'h0810,
        16'h0180, 16'h1080, 16'h0280, 16'h2080, 16'h0480, 16'h4080, 16'h0880, 16'h8080,
        16'h1040, 16'h0140, 16'h2040, 16'h0240, 16'h4040, 16'h0440, 16'h8040, 16'h0840,
        16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

endpackage

>>> rtl/core/flsc_regs.sv
// APB-style configuration registers of the flash LED sequence controller.
// Depends on flsc_pkg for the register codes, reset values and the t_cfg struct.
module flsc_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [flsc_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [flsc_pkg::DATA_BITS-1:0]     pwdata,
    output logic [flsc_pkg::DATA_BITS-1:0]     prdata,
    output logic                               pready,
    output flsc_pkg::t_cfg                     o_cfg
);

    flsc_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_debounce <= flsc_pkg::BUTTON_DEBOUNCE_RST;
            r_cfg.flash_debounce  <= flsc_pkg::FLASH_DEBOUNCE_RST;
            r_cfg.long_press      <= flsc_pkg::LONG_PRESS_RST;
            r_cfg.exposure_limit  <= flsc_pkg::EXPOSURE_LIMIT_RST;
            r_cfg.pilot_pattern   <= flsc_pkg::PILOT_PATTERN_RST;
        end else if (wr_en) begin
            case (reg_sel)
                flsc_pkg::REG_BUTTON_DEBOUNCE: r_cfg.button_debounce <= pwdata[7:0];
                flsc_pkg::REG_FLASH_DEBOUNCE:  r_cfg.flash_debounce  <= pwdata[7:0];
                flsc_pkg::REG_LONG_PRESS:      r_cfg.long_press      <= pwdata[15:0];
                flsc_pkg::REG_EXPOSURE_LIMIT:  r_cfg.exposure_limit  <= pwdata[15:0];
                flsc_pkg::REG_PILOT_PATTERN:
                    r_cfg.pilot_pattern <= pwdata[flsc_pkg::PATTERN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            flsc_pkg::REG_BUTTON_DEBOUNCE: prdata = 32'(r_cfg.button_debounce);
            flsc_pkg::REG_FLASH_DEBOUNCE:  prdata = 32'(r_cfg.flash_debounce);
            flsc_pkg::REG_LONG_PRESS:      prdata = 32'(r_cfg.long_press);
            flsc_pkg::REG_EXPOSURE_LIMIT:  prdata = 32'(r_cfg.exposure_limit);
            flsc_pkg::REG_PILOT_PATTERN:   prdata = 32'(r_cfg.pilot_pattern);
            default:                       prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/flsc_engine.sv
// Event engine of the flash LED sequence controller: holds all sequence state and
// computes the state after one item. Depends on flsc_pkg for types and the LED table.
module flsc_engine #(
    parameter int LED_TOTAL = flsc_pkg::LED_TOTAL_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [1:0]     i_kind,
    input  logic           i_level,
    input  flsc_pkg::t_cfg i_cfg,
    output flsc_pkg::t_view o_view
);

    localparam logic [flsc_pkg::INDEX_BITS-1:0] LAST_POS = flsc_pkg::INDEX_BITS'(LED_TOTAL);

    logic [31:0] r_tick, n_tick;
    logic [31:0] r_last_btn, n_last_btn;
    logic [31:0] r_last_fl, n_last_fl;
    flsc_pkg::t_phase r_phase, n_phase;
    logic r_pilot_on, n_pilot_on;
    logic [flsc_pkg::INDEX_BITS-1:0] r_pos, n_pos;
    flsc_pkg::t_pattern r_staged, n_staged;
    flsc_pkg::t_pattern r_shown, n_shown;
    logic r_on, n_on;
    logic r_wake, n_wake;
    logic r_trig, n_trig;
    logic r_ready, n_ready;
    logic [15:0] r_wd, n_wd;
    logic r_wd_run, n_wd_run;

    logic [31:0] tick_inc;
    logic [31:0] btn_age;
    logic [31:0] fl_age;
    logic [31:0] hold_age;
    logic [15:0] wd_inc;
    logic [flsc_pkg::INDEX_BITS-1:0] pos_inc;

    assign tick_inc = r_tick + 32'd1;
    assign btn_age  = r_tick - r_last_btn;
    assign fl_age   = r_tick - r_last_fl;
    assign hold_age = tick_inc - r_last_btn;
    assign wd_inc   = (r_wd != flsc_pkg::WATCHDOG_MAX) ? r_wd + 16'd1 : r_wd;
    assign pos_inc  = (r_pos < LAST_POS) ? r_pos + 1'b1 : r_pos;

    always_comb begin
        n_tick     = r_tick;
        n_last_btn = r_last_btn;
        n_last_fl  = r_last_fl;
        n_phase    = r_phase;
        n_pilot_on = r_pilot_on;
        n_pos      = r_pos;
        n_staged   = r_staged;
        n_shown    = r_shown;
        n_on       = r_on;
        n_wake     = r_wake;
        n_trig     = r_trig;
        n_ready    = r_ready;
        n_wd       = r_wd;
        n_wd_run   = r_wd_run;
        if (i_fire) begin
            case (i_kind)
                flsc_pkg::KIND_TICK: begin
                    n_tick = tick_inc;
                    if (r_phase == flsc_pkg::PHASE_PRESSED
                            && hold_age > 32'(i_cfg.long_press)) begin
                        n_phase  = flsc_pkg::PHASE_LONG;
                        n_on     = 1'b0;
                        n_pos    = '0;
                        n_staged = flsc_pkg::LED_TABLE[0];
                        n_ready  = 1'b0;
                        n_wake   = 1'b1;
                        n_trig   = 1'b1;
                    end
                    if (r_wd_run) begin
                        n_wd = wd_inc;
                        if (wd_inc >= i_cfg.exposure_limit) begin
                            n_wd_run = 1'b0;
                            n_on     = 1'b0;
                            n_wake   = 1'b0;
                            n_trig   = 1'b0;
                            n_ready  = 1'b1;
                        end
                    end
                end
                flsc_pkg::KIND_BUTTON: begin
                    n_last_btn = r_tick;
                    if (btn_age > 32'(i_cfg.button_debounce)) begin
                        if (i_level) begin
                            n_phase = flsc_pkg::PHASE_RELEASED;
                        end else begin
                            n_phase    = flsc_pkg::PHASE_PRESSED;
                            n_wake     = 1'b0;
                            n_trig     = 1'b0;
                            n_ready    = 1'b1;
                            n_pilot_on = ~r_pilot_on;
                            if (r_pilot_on) begin
                                n_on = 1'b0;
                            end else begin
                                n_staged = i_cfg.pilot_pattern;
                                n_shown  = i_cfg.pilot_pattern;
                                n_on     = 1'b1;
                            end
                        end
                    end
                end
                flsc_pkg::KIND_FLASH: begin
                    n_last_fl = r_tick;
                    if (fl_age > 32'(i_cfg.flash_debounce)) begin
                        if (!i_level) begin
                            n_shown  = r_staged;
                            n_on     = 1'b1;
                            n_wd     = '0;
                            n_wd_run = 1'b1;
                            n_pos    = pos_inc;
                            if (pos_inc >= LAST_POS) begin
                                n_wake  = 1'b0;
                                n_trig  = 1'b0;
                                n_ready = 1'b1;
                            end else begin
                                n_staged = flsc_pkg::LED_TABLE[pos_inc[5:0]];
                            end
                        end else begin
                            n_on = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_last_btn <= '0;
            r_last_fl  <= '0;
            r_phase    <= flsc_pkg::PHASE_RELEASED;
            r_pilot_on <= 1'b0;
            r_pos      <= '0;
            r_staged   <= flsc_pkg::LED_TABLE[0];
            r_shown    <= '0;
            r_on       <= 1'b0;
            r_wake     <= 1'b0;
            r_trig     <= 1'b0;
            r_ready    <= 1'b1;
            r_wd       <= '0;
            r_wd_run   <= 1'b0;
        end else begin
            r_tick     <= n_tick;
            r_last_btn <= n_last_btn;
            r_last_fl  <= n_last_fl;
            r_phase    <= n_phase;
            r_pilot_on <= n_pilot_on;
            r_pos      <= n_pos;
            r_staged   <= n_staged;
            r_shown    <= n_shown;
            r_on       <= n_on;
            r_wake     <= n_wake;
            r_trig     <= n_trig;
            r_ready    <= n_ready;
            r_wd       <= n_wd;
            r_wd_run   <= n_wd_run;
        end
    end

    assign o_view.led_drive      = n_shown;
    assign o_view.led_enable     = n_on;
    assign o_view.camera_wake    = n_wake;
    assign o_view.camera_trigger = n_trig;
    assign o_view.ready_light    = n_ready;
    assign o_view.shot_index     = n_pos;
    assign o_view.phase          = n_phase;

endmodule

>>> rtl/core/flash_led_sequence_controller_core.sv
// Top level of the flash LED sequence controller: input register, event engine,
// result register and configuration port. Depends on flsc_pkg, flsc_regs, flsc_engine.
//
// Usage: each input item is one event (kind 0 tick, 1 start-button edge, 2 flash edge)
// with the sampled active-low pin level, offered on i_valid and held while o_stall is
// high. Every item gives exactly one result item on o_valid with the LED pattern,
// LED enable, camera lines, ready light, shot index and button phase after the event.
// Kind 3 changes nothing and still gives a result showing the current state.
// After acceptance the item waits in the input register; once the result register is free,
// the engine updates the state and loads the result register, which drives o_valid.
// Throughput is one item per cycle while i_stall is low; the state update is a single pass of
// compare and increment logic through the engine, so consecutive items never wait on each other.
// When the receiver raises i_stall the result is held; the input register still takes
// one more item, after which o_stall rises until the result is taken.
// Reset (i_rst_n low, synchronous) empties both registers, restores the register
// defaults and returns the sequence to idle with the first table pattern staged.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16 of the APB port.
module flash_led_sequence_controller_core #(
    parameter int LED_TOTAL = flsc_pkg::LED_TOTAL_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_kind,
    input  logic                                 i_pin_level,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [flsc_pkg::PATTERN_BITS-1:0]    o_led_drive,
    output logic                                 o_led_enable,
    output logic                                 o_camera_wake,
    output logic                                 o_camera_trigger,
    output logic                                 o_ready_light,
    output logic [flsc_pkg::INDEX_BITS-1:0]      o_shot_index,
    output logic [1:0]                           o_button_phase,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [flsc_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [flsc_pkg::DATA_BITS-1:0]       pwdata,
    output logic [flsc_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready
);

    flsc_pkg::t_cfg  cfg;
    flsc_pkg::t_view view;
    flsc_pkg::t_view r_out;

    logic       r_in_valid;
    logic [1:0] r_kind;
    logic       r_level;
    logic       r_out_valid;
    logic       out_free;
    logic       advance;
    logic       accept;

    assign out_free = ~r_out_valid | ~i_stall;
    assign advance  = r_in_valid & out_free;
    assign o_stall  = r_in_valid & ~out_free;
    assign accept   = i_valid & ~o_stall;

    flsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    flsc_engine #(
        .LED_TOTAL (LED_TOTAL)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_kind  (r_kind),
        .i_level (r_level),
        .i_cfg   (cfg),
        .o_view  (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_level <= i_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (~i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= view;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_led_drive      = r_out.led_drive;
    assign o_led_enable     = r_out.led_enable;
    assign o_camera_wake    = r_out.camera_wake;
    assign o_camera_trigger = r_out.camera_trigger;
    assign o_ready_light    = r_out.ready_light;
    assign o_shot_index     = r_out.shot_index;
    assign o_button_phase   = 2'(r_out.phase);

endmodule

>>> rtl/core/flsc_checker.sv
// Port checker of the flash LED sequence controller, bound to the top level.
// Depends on flsc_pkg and the assertion macros in the controller's header.
`include "flash_led_sequence_controller_core_assert.svh"

module flsc_checker #(
    parameter int LED_TOTAL = flsc_pkg::LED_TOTAL_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [flsc_pkg::PATTERN_BITS-1:0] o_led_drive,
    input logic                              o_camera_wake,
    input logic                              o_camera_trigger,
    input logic                              o_ready_light,
    input logic [flsc_pkg::INDEX_BITS-1:0]   o_shot_index
);

    localparam logic [flsc_pkg::INDEX_BITS-1:0] LAST_POS = flsc_pkg::INDEX_BITS'(LED_TOTAL);

    // A stalled result item stays valid and keeps its pattern.
    `FLSC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_led_drive))

    // The camera is always woken and triggered together.
    `FLSC_ASSERT_NOW(a_cam_pair, i_clk, i_rst_n, o_valid, o_camera_wake == o_camera_trigger)

    // The ready light is on exactly when the camera is stopped.
    `FLSC_ASSERT_NOW(a_ready, i_clk, i_rst_n, o_valid, o_ready_light != o_camera_wake)

    // The shot index never passes the number of LEDs.
    `FLSC_ASSERT_NOW(a_index, i_clk, i_rst_n, o_valid, o_shot_index <= LAST_POS)

endmodule

bind flash_led_sequence_controller_core flsc_checker #(
    .LED_TOTAL (LED_TOTAL)
) u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_led_drive      (o_led_drive),
    .o_camera_wake    (o_camera_wake),
    .o_camera_trigger (o_camera_trigger),
    .o_ready_light    (o_ready_light),
    .o_shot_index     (o_shot_index)
);

>>> sim/tb_flash_led_sequence_controller_core.sv
`timescale 1ns / 100ps
// Testbench for the flash LED sequence controller core: event items in, one status item out.
// A scoreboard class predicts every status item and checks it; depends on flsc_pkg and the RTL.
module tb_flash_led_sequence_controller_core;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam logic       PIN_ACTIVE   = 1'b0;
    localparam logic       PIN_IDLE     = 1'b1;

    class flash_sequence_scoreboard;
        logic [7:0]         button_gap;
        logic [7:0]         flash_gap;
        logic [15:0]        hold_ticks;
        logic [15:0]        exposure_ticks;
        flsc_pkg::t_pattern pilot;
        logic [31:0]        now;
        logic [31:0]        button_at;
        logic [31:0]        flash_at;
        flsc_pkg::t_phase   phase;
        logic               pilot_lit;
        logic [6:0]         position;
        flsc_pkg::t_pattern staged;
        flsc_pkg::t_pattern shown;
        logic               enabled;
        logic               wake;
        logic               trigger;
        logic               idle_light;
        logic               dog_running;
        logic [15:0]        dog_count;
        flsc_pkg::t_view    expected_views[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        peak_index;
        int unsigned        expiries;
        int unsigned        long_presses;

        function new();
            button_gap = flsc_pkg::BUTTON_DEBOUNCE_RST;
            flash_gap = flsc_pkg::FLASH_DEBOUNCE_RST;
            hold_ticks = flsc_pkg::LONG_PRESS_RST;
            exposure_ticks = flsc_pkg::EXPOSURE_LIMIT_RST;
            pilot = flsc_pkg::PILOT_PATTERN_RST;
            now = '0;
            button_at = '0;
            flash_at = '0;
            phase = flsc_pkg::PHASE_RELEASED;
            pilot_lit = 1'b0;
            position = '0;
            staged = flsc_pkg::LED_TABLE[0];
            shown = '0;
            enabled = 1'b0;
            wake = 1'b0;
            trigger = 1'b0;
            idle_light = 1'b1;
            dog_running = 1'b0;
            dog_count = '0;
            mismatches = 0;
            checked = 0;
            peak_index = 0;
            expiries = 0;
            long_presses = 0;
        endfunction

        function void flag(input string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        function void set_reg(input flsc_pkg::t_reg idx, input logic [31:0] value);
            case (idx)
                flsc_pkg::REG_BUTTON_DEBOUNCE: button_gap = value[7:0];
                flsc_pkg::REG_FLASH_DEBOUNCE:  flash_gap = value[7:0];
                flsc_pkg::REG_LONG_PRESS:      hold_ticks = value[15:0];
                flsc_pkg::REG_EXPOSURE_LIMIT:  exposure_ticks = value[15:0];
                flsc_pkg::REG_PILOT_PATTERN:   pilot = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(input flsc_pkg::t_reg idx);
            case (idx)
                flsc_pkg::REG_BUTTON_DEBOUNCE: return {24'd0, button_gap};
                flsc_pkg::REG_FLASH_DEBOUNCE:  return {24'd0, flash_gap};
                flsc_pkg::REG_LONG_PRESS:      return {16'd0, hold_ticks};
                flsc_pkg::REG_EXPOSURE_LIMIT:  return {16'd0, exposure_ticks};
                flsc_pkg::REG_PILOT_PATTERN:   return {16'd0, pilot};
                default:                       return '0;
            endcase
        endfunction

        function void wake_camera();
            enabled = 1'b0;
            idle_light = 1'b0;
            wake = 1'b1;
            trigger = 1'b1;
        endfunction

        function void park_camera();
            trigger = 1'b0;
            wake = 1'b0;
            idle_light = 1'b1;
        endfunction

        function void count_tick();
            now = now + 32'd1;
            if (phase == flsc_pkg::PHASE_PRESSED && (now - button_at) > {16'd0, hold_ticks}) begin
                phase = flsc_pkg::PHASE_LONG;
                enabled = 1'b0;
                position = '0;
                staged = flsc_pkg::LED_TABLE[0];
                wake_camera();
                long_presses++;
            end
            if (dog_running) begin
                if (dog_count != flsc_pkg::WATCHDOG_MAX) begin
                    dog_count = dog_count + 16'd1;
                end
                if (dog_count >= exposure_ticks) begin
                    dog_running = 1'b0;
                    enabled = 1'b0;
                    park_camera();
                    expiries++;
                end
            end
        endfunction

        function void handle_button(input logic level);
            if ((now - button_at) > {24'd0, button_gap}) begin
                phase = level ? flsc_pkg::PHASE_RELEASED : flsc_pkg::PHASE_PRESSED;
                if (phase == flsc_pkg::PHASE_PRESSED) begin
                    park_camera();
                    if (pilot_lit) begin
                        enabled = 1'b0;
                    end else begin
                        staged = pilot;
                        shown = staged;
                        enabled = 1'b1;
                    end
                    pilot_lit = !pilot_lit;
                end
            end
            button_at = now;
        endfunction

        function void handle_flash(input logic level);
            if ((now - flash_at) > {24'd0, flash_gap}) begin
                if (!level) begin
                    shown = staged;
                    enabled = 1'b1;
                    dog_count = '0;
                    dog_running = 1'b1;
                    if (position < flsc_pkg::LED_TOTAL_DEF) begin
                        position = position + 7'd1;
                    end
                    if (position >= flsc_pkg::LED_TOTAL_DEF) begin
                        park_camera();
                    end else begin
                        staged = flsc_pkg::LED_TABLE[position[5:0]];
                    end
                    if (position > peak_index) begin
                        peak_index = position;
                    end
                end else begin
                    enabled = 1'b0;
                end
            end
            flash_at = now;
        endfunction

        function void note_event(input logic [1:0] kind, input logic level);
            flsc_pkg::t_view view;
            case (kind)
                flsc_pkg::KIND_TICK:   count_tick();
                flsc_pkg::KIND_BUTTON: handle_button(level);
                flsc_pkg::KIND_FLASH:  handle_flash(level);
                default: ;
            endcase
            view.led_drive = shown;
            view.led_enable = enabled;
            view.camera_wake = wake;
            view.camera_trigger = trigger;
            view.ready_light = idle_light;
            view.shot_index = position;
            view.phase = phase;
            expected_views.push_back(view);
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want) begin
                flag($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
            end
        endfunction

        function void check_view(input flsc_pkg::t_view got);
            flsc_pkg::t_view want;
            if (expected_views.size() == 0) begin
                flag("status item arrived with no event item pending");
                return;
            end
            want = expected_views.pop_front();
            checked++;
            compare_field("led_drive", want.led_drive, got.led_drive);
            compare_field("led_enable", want.led_enable, got.led_enable);
            compare_field("camera_wake", want.camera_wake, got.camera_wake);
            compare_field("camera_trigger", want.camera_trigger, got.camera_trigger);
            compare_field("ready_light", want.ready_light, got.ready_light);
            compare_field("shot_index", want.shot_index, got.shot_index);
            compare_field("button_phase", want.phase, got.phase);
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic [1:0]                           i_kind;
    logic                                 i_pin_level;
    logic                                 o_valid;
    logic                                 i_stall;
    flsc_pkg::t_pattern                   o_led_drive;
    logic                                 o_led_enable;
    logic                                 o_camera_wake;
    logic                                 o_camera_trigger;
    logic                                 o_ready_light;
    logic [flsc_pkg::INDEX_BITS-1:0]      o_shot_index;
    logic [1:0]                           o_button_phase;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [flsc_pkg::ADDR_BITS-1:0]       paddr;
    logic [flsc_pkg::DATA_BITS-1:0]       pwdata;
    logic [flsc_pkg::DATA_BITS-1:0]       prdata;
    logic                                 pready;

    flash_sequence_scoreboard model;
    flsc_pkg::t_view          seen_view;
    int unsigned              send_idle_pct;
    int unsigned              recv_stall_pct;
    int unsigned              items_sent;
    int unsigned              settings_applied;

    flash_led_sequence_controller_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_pin_level     (i_pin_level),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_led_drive     (o_led_drive),
        .o_led_enable    (o_led_enable),
        .o_camera_wake   (o_camera_wake),
        .o_camera_trigger(o_camera_trigger),
        .o_ready_light   (o_ready_light),
        .o_shot_index    (o_shot_index),
        .o_button_phase  (o_button_phase),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_view.led_drive = o_led_drive;
            seen_view.led_enable = o_led_enable;
            seen_view.camera_wake = o_camera_wake;
            seen_view.camera_trigger = o_camera_trigger;
            seen_view.ready_light = o_ready_light;
            seen_view.shot_index = o_shot_index;
            seen_view.phase = flsc_pkg::t_phase'(o_button_phase);
            model.check_view(seen_view);
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic level);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_pin_level <= level;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        model.note_event(kind, level);
        items_sent++;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_item(flsc_pkg::KIND_TICK, 1'($urandom_range(1)));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (model.expected_views.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [31:0] reg_mask(input flsc_pkg::t_reg idx);
        if (idx == flsc_pkg::REG_BUTTON_DEBOUNCE || idx == flsc_pkg::REG_FLASH_DEBOUNCE) begin
            return 32'h0000_00FF;
        end
        return 32'h0000_FFFF;
    endfunction

    task automatic read_reg(input flsc_pkg::t_reg idx);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if ((prdata & reg_mask(idx)) !== model.reg_value(idx)) begin
            model.flag($sformatf("register %s reads %0h, expected %0h", idx.name(), prdata,
                                 model.reg_value(idx)));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input flsc_pkg::t_reg idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        model.set_reg(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        read_reg(idx);
    endtask

    task automatic apply_settings(input logic [7:0] button_gap, input logic [7:0] flash_gap,
                                  input logic [15:0] hold, input logic [15:0] exposure,
                                  input flsc_pkg::t_pattern pattern);
        wait_idle();
        write_reg(flsc_pkg::REG_BUTTON_DEBOUNCE, {24'd0, button_gap});
        write_reg(flsc_pkg::REG_FLASH_DEBOUNCE, {24'd0, flash_gap});
        write_reg(flsc_pkg::REG_LONG_PRESS, {16'd0, hold});
        write_reg(flsc_pkg::REG_EXPOSURE_LIMIT, {16'd0, exposure});
        write_reg(flsc_pkg::REG_PILOT_PATTERN, {16'd0, pattern});
        settings_applied++;
    endtask

    // Long debounce windows are only waited out now and then, so most edges stay cheap.
    function automatic int unsigned gap_ticks(input int unsigned window);
        if (window < 32 || $urandom_range(3) == 0) begin
            return window + 1 + $urandom_range(2);
        end
        return $urandom_range(3);
    endfunction

    task automatic shot_run();
        int unsigned shots;
        send_ticks(gap_ticks(model.button_gap));
        send_item(flsc_pkg::KIND_BUTTON, PIN_ACTIVE);
        if (model.hold_ticks < 64) begin
            send_ticks(model.hold_ticks + 1 + $urandom_range(1));
        end else begin
            send_ticks($urandom_range(1, 4));
        end
        send_ticks(gap_ticks(model.button_gap));
        send_item(flsc_pkg::KIND_BUTTON, PIN_IDLE);
        if (model.flash_gap < 32) begin
            shots = ($urandom_range(99) < 15) ? $urandom_range(55, 66) : $urandom_range(1, 8);
        end else begin
            shots = $urandom_range(1, 3);
        end
        repeat (shots) begin
            send_ticks(gap_ticks(model.flash_gap) + $urandom_range(2));
            send_item(flsc_pkg::KIND_FLASH, PIN_ACTIVE);
            if ($urandom_range(99) < 60) begin
                send_ticks($urandom_range(model.flash_gap + 1));
                send_item(flsc_pkg::KIND_FLASH, PIN_IDLE);
            end
        end
    endtask

    task automatic short_press();
        send_ticks(gap_ticks(model.button_gap));
        send_item(flsc_pkg::KIND_BUTTON, PIN_ACTIVE);
        send_ticks($urandom_range(3));
        send_ticks(gap_ticks(model.button_gap));
        send_item(flsc_pkg::KIND_BUTTON, PIN_IDLE);
    endtask

    task automatic random_items(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        start = items_sent;
        while (items_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                shot_run();
            end else if (pick < 50) begin
                short_press();
            end else if (pick < 65) begin
                send_ticks(($urandom_range(9) == 0) ? $urandom_range(20, 80) :
                           $urandom_range(1, 12));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(2'($urandom_range(3)), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        model = new();
        send_idle_pct = 16;
        recv_stall_pct = 85;
        items_sent = 0;
        settings_applied = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = flsc_pkg::KIND_TICK;
        i_pin_level = PIN_IDLE;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: unknown kinds, then edges that fall inside the debounce window.
        send_item(KIND_UNKNOWN, PIN_ACTIVE);
        send_item(KIND_UNKNOWN, PIN_IDLE);
        send_item(flsc_pkg::KIND_TICK, PIN_IDLE);
        send_item(flsc_pkg::KIND_FLASH, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_BUTTON, PIN_ACTIVE);
        wait_idle();
        read_reg(flsc_pkg::REG_BUTTON_DEBOUNCE);
        read_reg(flsc_pkg::REG_FLASH_DEBOUNCE);
        read_reg(flsc_pkg::REG_LONG_PRESS);
        read_reg(flsc_pkg::REG_EXPOSURE_LIMIT);
        read_reg(flsc_pkg::REG_PILOT_PATTERN);

        apply_settings(8'd0, 8'd0, 16'd2, 16'd1, 16'h8000);
        send_item(flsc_pkg::KIND_TICK, PIN_IDLE);
        send_item(flsc_pkg::KIND_BUTTON, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_BUTTON, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_TICK, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_BUTTON, PIN_ACTIVE);
        send_ticks(3);
        send_item(flsc_pkg::KIND_BUTTON, PIN_IDLE);
        send_item(flsc_pkg::KIND_FLASH, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_FLASH, PIN_IDLE);
        send_item(flsc_pkg::KIND_TICK, PIN_IDLE);
        send_item(flsc_pkg::KIND_FLASH, PIN_IDLE);
        send_item(flsc_pkg::KIND_TICK, PIN_IDLE);
        send_item(flsc_pkg::KIND_FLASH, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_TICK, PIN_IDLE);
        send_item(flsc_pkg::KIND_BUTTON, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_TICK, PIN_IDLE);
        send_item(flsc_pkg::KIND_BUTTON, PIN_IDLE);
        send_item(flsc_pkg::KIND_TICK, PIN_IDLE);
        send_item(flsc_pkg::KIND_FLASH, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_BUTTON, PIN_ACTIVE);
        send_ticks(2);
        send_item(flsc_pkg::KIND_FLASH, PIN_ACTIVE);
        send_item(flsc_pkg::KIND_TICK, PIN_IDLE);

        apply_settings(8'd2, 8'd1, 16'd3, 16'd5, flsc_pkg::t_pattern'($urandom));
        random_items(450);

        apply_settings(8'($urandom_range(4)), 8'd0, 16'd0, 16'd1, 16'h0000);
        send_idle_pct = 85;
        recv_stall_pct = 16;
        random_items(450);

        apply_settings(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_items(150);

        apply_settings(8'($urandom_range(7)), 8'($urandom_range(7)),
                       16'($urandom_range(20)), 16'($urandom_range(1, 40)),
                       flsc_pkg::t_pattern'($urandom));
        random_items(250);

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d status items from %0d event items over %0d register settings.",
                 model.checked, items_sent, settings_applied);
        $display("Long presses %0d, watchdog expiries %0d, deepest shot index %0d.",
                 model.long_presses, model.expiries, model.peak_index);
        if (model.mismatches == 0 && model.expected_views.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("Failures: %0d", model.mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule
